@@ src/ljfa_pkg.sv @@
// ----------------------------------------------------------------------------
// ljfa_pkg
// Shared widths and saturating product helpers for the pair force accumulator.
// ----------------------------------------------------------------------------
package ljfa_pkg;

    localparam int unsigned POS_W   = 32;
    localparam int unsigned WIDE_W  = 64;
    localparam int unsigned PROD_W  = 128;
    localparam int unsigned DIST_W  = 33;
    localparam int unsigned FORCE_W = 48;

    localparam logic [1:0] REG_LJ_SCALE = 2'd0;
    localparam logic [1:0] REG_SIGMA    = 2'd1;
    localparam logic [1:0] REG_MIN_DIST = 2'd2;

    localparam logic [31:0] LJ_SCALE_RST = 32'd65536;
    localparam logic [31:0] SIGMA_RST    = 32'd65536;
    localparam logic [31:0] MIN_DIST_RST = 32'd13107;

    // floor(p / 2^32), saturating at all ones
    function automatic logic [63:0] sat_shr32(input logic [127:0] p);
        logic [63:0] r;
        begin
            r = (p[127:96] != 32'd0) ? {64{1'b1}} : p[95:32];
            return r;
        end
    endfunction

    // floor(p / 2^16), saturating at all ones
    function automatic logic [63:0] sat_shr16(input logic [127:0] p);
        logic [63:0] r;
        begin
            r = (p[127:80] != 48'd0) ? {64{1'b1}} : p[79:16];
            return r;
        end
    endfunction

endpackage

@@ src/lennard_jones_force_accumulator_core.sv @@
// ----------------------------------------------------------------------------
// lennard_jones_force_accumulator_core
// Lennard-Jones pair force accumulator on one shared multiplier and divider.
// ----------------------------------------------------------------------------
// Each input request carries the target and one neighbour position with the
// is_self and last flags; it is taken when in_valid is high and in_stall low.
// in_stall stays high while a request is being worked on.
// A self request, or a neighbour at or below min_distance, adds nothing; a self
// request goes straight to the finish state, a close one once the root is known.
// For a full neighbour the 64-step divider runs four times (sigma/dist and one
// unit vector component per axis), the 4-partial multiplier twelve times and
// the square root 32 steps.
// On a last request the summed force goes to an output register (out_valid)
// and the sums clear. If out_stall holds an earlier force, the block waits
// with in_stall high until it is taken; the output never changes while stalled.
// Configuration writes (cfg_we, cfg_index, cfg_data) are taken at any edge and
// must only be made while idle. Reset sets the registers to 1.0, 1.0 and
// about 0.2 and clears the sums; no output is pending after reset.
// ----------------------------------------------------------------------------
module lennard_jones_force_accumulator_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] target_x,
    input  logic [31:0] target_y,
    input  logic [31:0] target_z,
    input  logic [31:0] other_x,
    input  logic [31:0] other_y,
    input  logic [31:0] other_z,
    input  logic        is_self,
    input  logic        last,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [47:0] force_x,
    output logic [47:0] force_y,
    output logic [47:0] force_z
);

    typedef enum logic [9:0] {
        ST_IDLE = 10'b0000000001,
        ST_SQ   = 10'b0000000010,
        ST_SQRT = 10'b0000000100,
        ST_DIVR = 10'b0000001000,
        ST_POW  = 10'b0000010000,
        ST_FMUL = 10'b0000100000,
        ST_UDIV = 10'b0001000000,
        ST_CMUL = 10'b0010000000,
        ST_ACC  = 10'b0100000000,
        ST_FIN  = 10'b1000000000
    } state_t;

    localparam logic [47:0] ACC_MAX = {1'b0, {47{1'b1}}};
    localparam logic [47:0] ACC_MIN = {1'b1, 47'd0};

    state_t       state_reg;
    logic [31:0]  lj_scale_reg;
    logic [31:0]  sigma_reg;
    logic [31:0]  min_dist_reg;
    logic [47:0]  sum_reg [3];
    logic [31:0]  a_reg [3];
    logic [2:0]   neg_reg;
    logic         last_reg;
    logic [2:0]   idx_reg;
    logic         launched_reg;
    logic [65:0]  s_reg;
    logic [63:0]  v_reg;
    logic [33:0]  rem_reg;
    logic [31:0]  root_reg;
    logic [4:0]   scnt_reg;
    logic [63:0]  r_reg;
    logic [63:0]  r2_reg;
    logic [63:0]  r4_reg;
    logic [63:0]  r8_reg;
    logic [63:0]  r6_reg;
    logic [63:0]  r14_reg;
    logic [63:0]  f_reg;
    logic         fneg_reg;
    logic [30:0]  u_reg;
    logic [46:0]  c_reg;
    logic         out_valid_reg;
    logic [47:0]  fx_reg;
    logic [47:0]  fy_reg;
    logic [47:0]  fz_reg;

    logic         mul_start;
    logic [63:0]  mul_a;
    logic [63:0]  mul_b;
    logic         mul_done;
    logic [127:0] mul_prod;
    logic         div_start;
    logic [63:0]  div_num;
    logic [63:0]  div_quo;
    logic         div_done;
    logic [63:0]  pow_res;
    logic [32:0]  root_dist;
    logic         too_close;
    logic [63:0]  half_r8;
    logic         fneg_now;
    logic [63:0]  mag;
    logic [35:0]  rem_sh;
    logic [35:0]  trial;
    logic         accept;
    logic         out_free;
    logic         out_emit;
    logic [32:0]  dx;
    logic [32:0]  dy;
    logic [32:0]  dz;
    logic [32:0]  dx_abs;
    logic [32:0]  dy_abs;
    logic [32:0]  dz_abs;
    logic [1:0]   cidx;
    logic [48:0]  c_signed;
    logic [48:0]  acc_sum;
    logic [47:0]  acc_sat;

    assign accept   = in_valid && (state_reg == ST_IDLE);
    assign in_stall = (state_reg != ST_IDLE);
    assign out_free = !out_valid_reg || !out_stall;
    assign out_emit = (state_reg == ST_FIN) && last_reg && out_free;
    assign cidx     = idx_reg[1:0];

    assign dx     = {target_x[31], target_x} - {other_x[31], other_x};
    assign dy     = {target_y[31], target_y} - {other_y[31], other_y};
    assign dz     = {target_z[31], target_z} - {other_z[31], other_z};
    assign dx_abs = dx[32] ? -dx : dx;
    assign dy_abs = dy[32] ? -dy : dy;
    assign dz_abs = dz[32] ? -dz : dz;

    assign root_dist = {root_reg, 1'b0};
    assign too_close = (root_dist <= {1'b0, min_dist_reg});
    assign half_r8   = {1'b0, r8_reg[63:1]};
    assign fneg_now  = r14_reg < half_r8;
    assign mag       = fneg_now ? (half_r8 - r14_reg) : (r14_reg - half_r8);
    assign pow_res   = ljfa_pkg::sat_shr32(mul_prod);

    assign rem_sh = {rem_reg, v_reg[63:62]};
    assign trial  = {2'b00, root_reg, 2'b01};

    // signed component and saturating accumulate
    assign c_signed = (fneg_reg ^ neg_reg[cidx]) ? -{2'b00, c_reg} : {2'b00, c_reg};
    assign acc_sum  = {sum_reg[cidx][47], sum_reg[cidx]} + c_signed;
    always_comb
    begin
        if (acc_sum[48] != acc_sum[47])
        begin
            acc_sat = acc_sum[48] ? ACC_MIN : ACC_MAX;
        end
        else
        begin
            acc_sat = acc_sum[47:0];
        end
    end

    // operand selection for the shared units
    always_comb
    begin
        mul_a     = '0;
        mul_b     = '0;
        mul_start = 1'b0;
        div_num   = '0;
        div_start = 1'b0;
        case (state_reg)
            ST_SQ:
            begin
                mul_a     = {32'd0, a_reg[cidx]};
                mul_b     = {32'd0, a_reg[cidx]};
                mul_start = !launched_reg;
            end
            ST_POW:
            begin
                case (idx_reg)
                    3'd0:
                    begin
                        mul_a = r_reg;
                        mul_b = r_reg;
                    end
                    3'd1:
                    begin
                        mul_a = r2_reg;
                        mul_b = r2_reg;
                    end
                    3'd2:
                    begin
                        mul_a = r4_reg;
                        mul_b = r4_reg;
                    end
                    3'd3:
                    begin
                        mul_a = r4_reg;
                        mul_b = r2_reg;
                    end
                    default:
                    begin
                        mul_a = r8_reg;
                        mul_b = r6_reg;
                    end
                endcase
                mul_start = !launched_reg;
            end
            ST_FMUL:
            begin
                mul_a     = mag;
                mul_b     = {32'd0, lj_scale_reg};
                mul_start = !launched_reg;
            end
            ST_CMUL:
            begin
                mul_a     = f_reg;
                mul_b     = {33'd0, u_reg};
                mul_start = !launched_reg;
            end
            ST_DIVR:
            begin
                div_num   = {sigma_reg, 32'd0};
                div_start = !launched_reg && !too_close;
            end
            ST_UDIV:
            begin
                div_num   = {2'b00, a_reg[cidx], 30'd0};
                div_start = !launched_reg;
            end
            default:
            begin
                mul_start = 1'b0;
            end
        endcase
    end

    ljfa_mul u_mul
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .prod  (mul_prod)
    );

    ljfa_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (root_dist),
        .done  (div_done),
        .quo   (div_quo)
    );

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lj_scale_reg <= ljfa_pkg::LJ_SCALE_RST;
            sigma_reg    <= ljfa_pkg::SIGMA_RST;
            min_dist_reg <= ljfa_pkg::MIN_DIST_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                ljfa_pkg::REG_LJ_SCALE: lj_scale_reg <= cfg_data;
                ljfa_pkg::REG_SIGMA:    sigma_reg    <= cfg_data;
                ljfa_pkg::REG_MIN_DIST: min_dist_reg <= cfg_data;
                default:                lj_scale_reg <= lj_scale_reg;
            endcase
        end
    end

    // sequencer and accumulators
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= 3'd0;
            launched_reg  <= 1'b0;
            scnt_reg      <= 5'd0;
            out_valid_reg <= 1'b0;
            sum_reg[0]    <= '0;
            sum_reg[1]    <= '0;
            sum_reg[2]    <= '0;
        end
        else
        begin
            out_valid_reg <= out_emit || (out_valid_reg && out_stall);
            if (mul_start || div_start)
            begin
                launched_reg <= 1'b1;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        idx_reg   <= 3'd0;
                        state_reg <= is_self ? ST_FIN : ST_SQ;
                    end
                end
                ST_SQ:
                begin
                    if (mul_done)
                    begin
                        launched_reg <= 1'b0;
                        if (idx_reg == 3'd2)
                        begin
                            scnt_reg  <= 5'd0;
                            state_reg <= ST_SQRT;
                        end
                        idx_reg <= idx_reg + 3'd1;
                    end
                end
                ST_SQRT:
                begin
                    scnt_reg <= scnt_reg + 5'd1;
                    if (scnt_reg == 5'd31)
                    begin
                        state_reg <= ST_DIVR;
                    end
                end
                ST_DIVR:
                begin
                    // close neighbour check once the root is complete
                    if (!launched_reg && too_close)
                    begin
                        state_reg <= ST_FIN;
                    end
                    else if (div_done)
                    begin
                        launched_reg <= 1'b0;
                        idx_reg      <= 3'd0;
                        state_reg    <= ST_POW;
                    end
                end
                ST_POW:
                begin
                    if (mul_done)
                    begin
                        launched_reg <= 1'b0;
                        idx_reg      <= idx_reg + 3'd1;
                        if (idx_reg == 3'd4)
                        begin
                            state_reg <= ST_FMUL;
                        end
                    end
                end
                ST_FMUL:
                begin
                    if (mul_done)
                    begin
                        launched_reg <= 1'b0;
                        idx_reg      <= 3'd0;
                        state_reg    <= ST_UDIV;
                    end
                end
                ST_UDIV:
                begin
                    if (div_done)
                    begin
                        launched_reg <= 1'b0;
                        state_reg    <= ST_CMUL;
                    end
                end
                ST_CMUL:
                begin
                    if (mul_done)
                    begin
                        launched_reg <= 1'b0;
                        state_reg    <= ST_ACC;
                    end
                end
                ST_ACC:
                begin
                    sum_reg[cidx] <= acc_sat;
                    idx_reg       <= idx_reg + 3'd1;
                    state_reg     <= (idx_reg == 3'd2) ? ST_FIN : ST_UDIV;
                end
                ST_FIN:
                begin
                    if (!last_reg)
                    begin
                        state_reg <= ST_IDLE;
                    end
                    else if (out_free)
                    begin
                        sum_reg[0]    <= '0;
                        sum_reg[1]    <= '0;
                        sum_reg[2]    <= '0;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_reg[0] <= dx_abs[31:0];
            a_reg[1] <= dy_abs[31:0];
            a_reg[2] <= dz_abs[31:0];
            neg_reg  <= {dz[32], dy[32], dx[32]};
            last_reg <= last;
            s_reg    <= '0;
        end
        if ((state_reg == ST_SQ) && mul_done)
        begin
            s_reg <= s_reg + {2'b00, mul_prod[63:0]};
            if (idx_reg == 3'd2)
            begin
                v_reg    <= s_reg[65:2] + mul_prod[65:2]
                            + {62'd0, ({1'b0, s_reg[1:0]} + {1'b0, mul_prod[1:0]}) > 3'd3
                                      ? 2'd1 : 2'd0};
                rem_reg  <= '0;
                root_reg <= '0;
            end
        end
        // one result bit per cycle of the root
        if (state_reg == ST_SQRT)
        begin
            v_reg <= {v_reg[61:0], 2'b00};
            if (rem_sh >= trial)
            begin
                rem_reg  <= rem_sh[33:0] - trial[33:0];
                root_reg <= {root_reg[30:0], 1'b1};
            end
            else
            begin
                rem_reg  <= rem_sh[33:0];
                root_reg <= {root_reg[30:0], 1'b0};
            end
        end
        if ((state_reg == ST_DIVR) && div_done)
        begin
            r_reg <= div_quo;
        end
        if ((state_reg == ST_POW) && mul_done)
        begin
            case (idx_reg)
                3'd0:    r2_reg  <= pow_res;
                3'd1:    r4_reg  <= pow_res;
                3'd2:    r8_reg  <= pow_res;
                3'd3:    r6_reg  <= pow_res;
                default: r14_reg <= pow_res;
            endcase
        end
        if ((state_reg == ST_FMUL) && mul_done)
        begin
            f_reg    <= ljfa_pkg::sat_shr16(mul_prod);
            fneg_reg <= fneg_now;
        end
        if ((state_reg == ST_UDIV) && div_done)
        begin
            u_reg <= (div_quo > 64'h4000_0000) ? 31'h4000_0000 : div_quo[30:0];
        end
        // floor(f*u/2^46) clamped to the positive accumulator limit
        if ((state_reg == ST_CMUL) && mul_done)
        begin
            c_reg <= (mul_prod[127:93] != 35'd0) ? {47{1'b1}} : mul_prod[92:46];
        end
        if (out_emit)
        begin
            fx_reg <= sum_reg[0];
            fy_reg <= sum_reg[1];
            fz_reg <= sum_reg[2];
        end
    end

    assign out_valid = out_valid_reg;
    assign force_x   = fx_reg;
    assign force_y   = fy_reg;
    assign force_z   = fz_reg;

endmodule

@@ src/ljfa_mul.sv @@
// ----------------------------------------------------------------------------
// ljfa_mul
// 64 x 64 multiplier built from four registered 32 x 32 partial products.
// ----------------------------------------------------------------------------
module ljfa_mul
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [63:0]  a,
    input  logic [63:0]  b,
    output logic         done,
    output logic [127:0] prod
);

    logic [63:0]  a_reg;
    logic [63:0]  b_reg;
    logic [2:0]   cnt_reg;
    logic         busy_reg;
    logic         pp_vld_reg;
    logic         done_reg;
    logic [63:0]  pp_reg;
    logic [1:0]   pp_sh_reg;
    logic [127:0] acc_reg;
    logic [31:0]  a_half;
    logic [31:0]  b_half;
    logic [127:0] pp_ext;
    logic [1:0]   pp_sh_next;

    assign a_half     = cnt_reg[1] ? a_reg[63:32] : a_reg[31:0];
    assign b_half     = cnt_reg[0] ? b_reg[63:32] : b_reg[31:0];
    assign pp_sh_next = {1'b0, cnt_reg[1]} + {1'b0, cnt_reg[0]};

    always_comb
    begin
        case (pp_sh_reg)
            2'd0:    pp_ext = {64'd0, pp_reg};
            2'd1:    pp_ext = {32'd0, pp_reg, 32'd0};
            default: pp_ext = {pp_reg, 64'd0};
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            cnt_reg    <= 3'd0;
            pp_vld_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg   <= 1'b1;
                cnt_reg    <= 3'd0;
                pp_vld_reg <= 1'b0;
            end
            else if (busy_reg)
            begin
                if (!cnt_reg[2])
                begin
                    pp_vld_reg <= 1'b1;
                    cnt_reg    <= cnt_reg + 3'd1;
                end
                else
                begin
                    pp_vld_reg <= 1'b0;
                    busy_reg   <= 1'b0;
                    done_reg   <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg   <= a;
            b_reg   <= b;
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            pp_reg    <= a_half * b_half;
            pp_sh_reg <= pp_sh_next;
            if (pp_vld_reg)
            begin
                acc_reg <= acc_reg + pp_ext;
            end
        end
    end

    assign done = done_reg;
    assign prod = acc_reg;

endmodule

@@ src/ljfa_div.sv @@
// ----------------------------------------------------------------------------
// ljfa_div
// Restoring divider, 64-bit numerator by 33-bit divisor, one bit a cycle.
// ----------------------------------------------------------------------------
module ljfa_div
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] num,
    input  logic [32:0] den,
    output logic        done,
    output logic [63:0] quo
);

    logic [63:0] num_reg;
    logic [32:0] den_reg;
    logic [32:0] rem_reg;
    logic [63:0] q_reg;
    logic [5:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [33:0] rem_sh;
    logic [33:0] rem_sub;
    logic        ge;

    assign rem_sh  = {rem_reg, num_reg[63]};
    assign ge      = rem_sh >= {1'b0, den_reg};
    assign rem_sub = rem_sh - {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= 6'd0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 6'd0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'd63)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= num;
            den_reg <= den;
            rem_reg <= '0;
            q_reg   <= '0;
        end
        else if (busy_reg)
        begin
            num_reg <= {num_reg[62:0], 1'b0};
            rem_reg <= ge ? rem_sub[32:0] : rem_sh[32:0];
            q_reg   <= {q_reg[62:0], ge};
        end
    end

    assign done = done_reg;
    assign quo  = q_reg;

endmodule
